// ===== rtl/core/tshf_pkg.sv =====
// ----------------------------------------------------------------------------
// tshf_pkg: shared types and constants for the turn signal / hazard flasher
// Field widths, flash mode and direction codes, and register indexes.
// ----------------------------------------------------------------------------
package tshf_pkg;

  localparam int unsigned ChanW  = 12;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LevelW = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_LEFT   = 2'd1,
    MODE_RIGHT  = 2'd2,
    MODE_HAZARD = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLINK_PERIOD = 3'd0,
    CFG_LAMP_ON      = 3'd1,
    CFG_LAMP_OFF     = 3'd2,
    CFG_LEFT_LOW     = 3'd3,
    CFG_LEFT_HIGH    = 3'd4,
    CFG_RIGHT_THRESH = 3'd5
  } cfg_idx_t;

  localparam logic [15:0]      BlinkPeriodRst = 16'd400;
  localparam logic [15:0]      LampOnRst      = 16'd2000;
  localparam logic [15:0]      LampOffRst     = 16'd1000;
  localparam logic [ChanW-1:0] LeftLowRst     = 12'd1300;
  localparam logic [ChanW-1:0] LeftHighRst    = 12'd1700;
  localparam logic [ChanW-1:0] RightThreshRst = 12'd1700;

endpackage

// ===== rtl/core/tshf_if.sv =====
// ----------------------------------------------------------------------------
// tshf_if: item channels of the flasher
// Valid/ready channels for control ticks in and lamp results out.
// ----------------------------------------------------------------------------
interface tshf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          new_frame;
  logic                          link_up;
  logic [tshf_pkg::ChanW-1:0]    left_channel;
  logic [tshf_pkg::ChanW-1:0]    right_channel;
  logic [tshf_pkg::TimeW-1:0]    now_ms;

  modport source (output valid, new_frame, link_up, left_channel, right_channel, now_ms,
                  input ready);
  modport sink (input valid, new_frame, link_up, left_channel, right_channel, now_ms,
                output ready);
endinterface

interface tshf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          left_write;
  logic                          right_write;
  logic [tshf_pkg::LevelW-1:0]   lamp_level;
  logic [1:0]                    active_mode;
  logic                          failsafe;
  logic                          vehicle_mode;

  modport source (output valid, left_write, right_write, lamp_level, active_mode,
                  failsafe, vehicle_mode, input ready);
  modport sink (input valid, left_write, right_write, lamp_level, active_mode,
                failsafe, vehicle_mode, output ready);
endinterface

// ===== rtl/core/turn_signal_hazard_flasher_top.sv =====
// ----------------------------------------------------------------------------
// turn_signal_hazard_flasher_top: turn signal and hazard flasher
// Output: the result is registered in the output register when the item is accepted.
// Throughput: 1 item per cycle; limited only by the single output register,
//   which is refilled in the same cycle it is drained.
// Reset (rst, sync, active high): failsafe latched, parked, flash off,
//   lamp dark, toggle timestamp 0, registers at their default values.
// ----------------------------------------------------------------------------
module turn_signal_hazard_flasher_top (
  input  logic                          clk,
  input  logic                          rst,
  tshf_in_if.sink                       in,
  tshf_out_if.source                    out,
  input  logic                          cfg_we,
  input  logic [tshf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [tshf_pkg::CfgW-1:0]     cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0]                 blink_period_ms;
  logic [15:0]                 lamp_on_level;
  logic [15:0]                 lamp_off_level;
  logic [tshf_pkg::ChanW-1:0]  left_band_low;
  logic [tshf_pkg::ChanW-1:0]  left_band_high;
  logic [tshf_pkg::ChanW-1:0]  right_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period_ms <= tshf_pkg::BlinkPeriodRst;
      lamp_on_level   <= tshf_pkg::LampOnRst;
      lamp_off_level  <= tshf_pkg::LampOffRst;
      left_band_low   <= tshf_pkg::LeftLowRst;
      left_band_high  <= tshf_pkg::LeftHighRst;
      right_threshold <= tshf_pkg::RightThreshRst;
    end else if (cfg_we) begin
      // indexes past the register list are dropped
      unique case (cfg_index)
        tshf_pkg::CFG_BLINK_PERIOD: blink_period_ms <= cfg_data;
        tshf_pkg::CFG_LAMP_ON:      lamp_on_level   <= cfg_data;
        tshf_pkg::CFG_LAMP_OFF:     lamp_off_level  <= cfg_data;
        tshf_pkg::CFG_LEFT_LOW:     left_band_low   <= cfg_data[tshf_pkg::ChanW-1:0];
        tshf_pkg::CFG_LEFT_HIGH:    left_band_high  <= cfg_data[tshf_pkg::ChanW-1:0];
        tshf_pkg::CFG_RIGHT_THRESH: right_threshold <= cfg_data[tshf_pkg::ChanW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flasher state
  // The queued mode of a running flash is always the request of the current
  // item, so it is taken straight from req_mode and needs no register.
  // --------------------------------------------------------------------------
  logic                        failsafe_latched, failsafe_latched_next;
  logic                        mode_parked, mode_parked_next;
  tshf_pkg::mode_t             flash_mode, flash_mode_next;
  tshf_pkg::dir_t              last_direction, last_direction_next;
  logic                        lamp_lit, lamp_lit_next;
  logic [tshf_pkg::TimeW-1:0]  last_toggle_ms, last_toggle_ms_next;

  // handshake: the output register frees up in the cycle it is taken
  logic accept;
  assign in.ready = !out.valid || out.ready;
  assign accept   = in.valid && in.ready;

  // per-item datapath
  logic                        left_req, right_req;
  tshf_pkg::mode_t             req_mode, run_mode;
  logic [tshf_pkg::TimeW-1:0]  elapsed;
  logic                        toggle;
  logic                        lw, rw;
  logic [15:0]                 level;

  always_comb begin
    failsafe_latched_next = failsafe_latched;
    mode_parked_next      = mode_parked;
    if (in.new_frame) begin
      failsafe_latched_next = !in.link_up;
      mode_parked_next      = !in.link_up;
    end

    left_req  = (left_band_low < in.left_channel) && (in.left_channel < left_band_high);
    right_req = in.right_channel > right_threshold;

    // request: parked forces hazard, both switches fall back to last single direction
    last_direction_next = last_direction;
    req_mode            = tshf_pkg::MODE_OFF;
    if (mode_parked_next) begin
      req_mode = tshf_pkg::MODE_HAZARD;
    end else if (left_req && !right_req) begin
      req_mode            = tshf_pkg::MODE_LEFT;
      last_direction_next = tshf_pkg::DIR_LEFT;
    end else if (right_req && !left_req) begin
      req_mode            = tshf_pkg::MODE_RIGHT;
      last_direction_next = tshf_pkg::DIR_RIGHT;
    end else if (left_req && right_req) begin
      if (last_direction == tshf_pkg::DIR_LEFT) begin
        req_mode = tshf_pkg::MODE_LEFT;
      end else if (last_direction == tshf_pkg::DIR_RIGHT) begin
        req_mode = tshf_pkg::MODE_RIGHT;
      end
    end

    // hazard preempts; otherwise a running flash keeps its mode
    if (req_mode == tshf_pkg::MODE_HAZARD || flash_mode == tshf_pkg::MODE_OFF) begin
      run_mode = req_mode;
    end else begin
      run_mode = flash_mode;
    end

    // wrapped elapsed time vs. period
    elapsed = in.now_ms - last_toggle_ms;
    toggle  = (run_mode != tshf_pkg::MODE_OFF) &&
              (elapsed > {{(tshf_pkg::TimeW-16){1'b0}}, blink_period_ms});

    flash_mode_next     = run_mode;
    lamp_lit_next       = lamp_lit;
    last_toggle_ms_next = last_toggle_ms;
    lw                  = 1'b0;
    rw                  = 1'b0;
    level               = '0;
    if (run_mode == tshf_pkg::MODE_OFF) begin
      lamp_lit_next = 1'b0;
    end else if (toggle) begin
      last_toggle_ms_next = in.now_ms;
      lamp_lit_next       = !lamp_lit;
      level = lamp_lit_next ? lamp_on_level : lamp_off_level;
      lw    = (run_mode == tshf_pkg::MODE_LEFT)  || (run_mode == tshf_pkg::MODE_HAZARD);
      rw    = (run_mode == tshf_pkg::MODE_RIGHT) || (run_mode == tshf_pkg::MODE_HAZARD);
      // end of an on/off cycle: take over the pending request
      if (!lamp_lit_next) begin
        flash_mode_next = req_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failsafe_latched <= 1'b1;
      mode_parked      <= 1'b1;
      flash_mode       <= tshf_pkg::MODE_OFF;
      last_direction   <= tshf_pkg::DIR_NONE;
      lamp_lit         <= 1'b0;
      last_toggle_ms   <= '0;
    end else if (accept) begin
      failsafe_latched <= failsafe_latched_next;
      mode_parked      <= mode_parked_next;
      flash_mode       <= flash_mode_next;
      last_direction   <= last_direction_next;
      lamp_lit         <= lamp_lit_next;
      last_toggle_ms   <= last_toggle_ms_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (accept) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out.left_write   <= lw;
      out.right_write  <= rw;
      out.lamp_level   <= level;
      out.active_mode  <= flash_mode_next;
      out.failsafe     <= failsafe_latched_next;
      out.vehicle_mode <= !mode_parked_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_level_only_on_write: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.left_write && !out.right_write |-> out.lamp_level == '0)
    else $error("lamp level set without a lamp write");

  a_failsafe_parked: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> out.failsafe == !out.vehicle_mode)
    else $error("failsafe and vehicle mode disagree");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in.ready |-> out.valid && !out.ready)
    else $error("input stalled with free output register");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out.valid)
    else $error("accepted item produced no result");

  // parked always ends up flashing hazard, even across the end of a cycle
  a_parked_is_hazard: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.vehicle_mode |-> out.active_mode == tshf_pkg::MODE_HAZARD)
    else $error("parked without hazard flashing");

endmodule

// ===== tb/sv/flasher_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// flasher_tb_pkg: lamp tracker for the turn signal / hazard flasher bench
// Shadows the flasher state and registers, computes the lamp result each
// accepted control tick should give and checks results against them in order.
// ----------------------------------------------------------------------------
package flasher_tb_pkg;
  import tshf_pkg::*;

  typedef struct packed {
    logic             new_frame;
    logic             link_up;
    logic [ChanW-1:0] left_channel;
    logic [ChanW-1:0] right_channel;
    logic [TimeW-1:0] now_ms;
  } tick_t;

  typedef struct packed {
    logic              left_write;
    logic              right_write;
    logic [LevelW-1:0] lamp_level;
    logic [1:0]        active_mode;
    logic              failsafe;
    logic              vehicle_mode;
  } lamp_t;

  class lamp_tracker;
    // register copies
    logic [15:0]      blink_period;
    logic [15:0]      on_level;
    logic [15:0]      off_level;
    logic [ChanW-1:0] left_low;
    logic [ChanW-1:0] left_high;
    logic [ChanW-1:0] right_thresh;
    // flasher state copies
    logic             failsafe_q;
    logic             parked_q;
    mode_t            cur_mode;
    mode_t            next_mode;
    dir_t             last_dir;
    logic             lamp_lit;
    logic [TimeW-1:0] last_toggle;

    lamp_t pending_lamps[$];
    int    ticks;
    int    lamps_seen;
    int    toggles;
    int    faults;

    function void clear();
      blink_period = BlinkPeriodRst;
      on_level     = LampOnRst;
      off_level    = LampOffRst;
      left_low     = LeftLowRst;
      left_high    = LeftHighRst;
      right_thresh = RightThreshRst;
      failsafe_q   = 1'b1;
      parked_q     = 1'b1;
      cur_mode     = MODE_OFF;
      next_mode    = MODE_OFF;
      last_dir     = DIR_NONE;
      lamp_lit     = 1'b0;
      last_toggle  = '0;
      pending_lamps.delete();
    endfunction

    // indexes outside the list leave everything as is
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CFG_BLINK_PERIOD: blink_period = data;
        CFG_LAMP_ON:      on_level     = data;
        CFG_LAMP_OFF:     off_level    = data;
        CFG_LEFT_LOW:     left_low     = data[ChanW-1:0];
        CFG_LEFT_HIGH:    left_high    = data[ChanW-1:0];
        CFG_RIGHT_THRESH: right_thresh = data[ChanW-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(tick_t t);
      mode_t            req;
      logic             left_req;
      logic             right_req;
      logic [TimeW-1:0] elapsed;
      lamp_t            e;
      e = '0;
      if (t.new_frame) begin
        failsafe_q = !t.link_up;
        parked_q   = !t.link_up;
      end
      left_req  = (left_low < t.left_channel) && (t.left_channel < left_high);
      right_req = t.right_channel > right_thresh;
      if (parked_q) begin
        req = MODE_HAZARD;
      end else if (left_req && !right_req) begin
        last_dir = DIR_LEFT;
        req = MODE_LEFT;
      end else if (right_req && !left_req) begin
        last_dir = DIR_RIGHT;
        req = MODE_RIGHT;
      end else if (left_req && right_req && last_dir == DIR_LEFT) begin
        req = MODE_LEFT;
      end else if (left_req && right_req && last_dir == DIR_RIGHT) begin
        req = MODE_RIGHT;
      end else begin
        req = MODE_OFF;
      end
      if (req == MODE_HAZARD || cur_mode == MODE_OFF) cur_mode = req;
      next_mode = req;

      elapsed = t.now_ms - last_toggle;
      if (cur_mode == MODE_OFF) begin
        lamp_lit = 1'b0;
      end else if (elapsed > {16'd0, blink_period}) begin
        last_toggle  = t.now_ms;
        lamp_lit     = !lamp_lit;
        e.lamp_level = lamp_lit ? on_level : off_level;
        e.left_write  = (cur_mode == MODE_LEFT) || (cur_mode == MODE_HAZARD);
        e.right_write = (cur_mode == MODE_RIGHT) || (cur_mode == MODE_HAZARD);
        if (!lamp_lit) cur_mode = next_mode;
        toggles++;
      end
      e.active_mode  = cur_mode;
      e.failsafe     = failsafe_q;
      e.vehicle_mode = !parked_q;
      pending_lamps.push_back(e);
      ticks++;
    endfunction

    function void check_lamp(lamp_t got);
      lamp_t e;
      if (pending_lamps.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("tb_top: lamp result with nothing pending: lw=%b rw=%b lvl=%0d mode=%0d",
                   got.left_write, got.right_write, got.lamp_level, got.active_mode);
        return;
      end
      e = pending_lamps.pop_front();
      lamps_seen++;
      if (got !== e) begin
        faults++;
        if (faults <= 10) begin
          $display("tb_top: lamp mismatch at result %0d", lamps_seen);
          $display("  exp lw=%b rw=%b lvl=%0d mode=%0d fs=%b veh=%b", e.left_write,
                   e.right_write, e.lamp_level, e.active_mode, e.failsafe, e.vehicle_mode);
          $display("  got lw=%b rw=%b lvl=%0d mode=%0d fs=%b veh=%b", got.left_write,
                   got.right_write, got.lamp_level, got.active_mode, got.failsafe,
                   got.vehicle_mode);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: bench for the turn signal / hazard flasher
// Sends control ticks over the input channel, predicts every lamp result in a
// shadow tracker and checks results in order, across several register sets
// and handshake idle patterns including a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import tshf_pkg::*;
  import flasher_tb_pkg::*;

  localparam int HoldCycles = 256;   // long output hold-off
  localparam int StallLimit = 4000;  // cycles with no item moving before giving up

  // register indexes past the end of the list; writes there must do nothing
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  // switch patterns held for a stretch of ticks
  typedef enum int {SEG_NONE, SEG_LEFT, SEG_RIGHT, SEG_BOTH, SEG_NOISE} switch_seg_t;

  typedef struct {
    logic [15:0]      period;
    logic [15:0]      on_lvl;
    logic [15:0]      off_lvl;
    logic [ChanW-1:0] lo;
    logic [ChanW-1:0] hi;
    logic [ChanW-1:0] rthr;
  } flasher_cfg_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  tshf_in_if  in_ch ();
  tshf_out_if out_ch ();

  lamp_tracker lamps;

  int               send_idle_pct;
  int               recv_idle_pct;
  bit               hold_off_req;
  int               stall_cycles;
  int               settings_used;
  logic [TimeW-1:0] clock_ms;       // last timestamp sent

  turn_signal_hazard_flasher_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in        (in_ch),
    .out       (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Receiver: random ready, or a counted hold-off when asked for one. Exactly
  // one assignment to ready per edge.
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HoldCycles - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: values are read at the edge, before any of this edge's
  // updates land, so the check sees exactly what the handshake saw.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    lamp_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.left_write   = out_ch.left_write;
      got.right_write  = out_ch.right_write;
      got.lamp_level   = out_ch.lamp_level;
      got.active_mode  = out_ch.active_mode;
      got.failsafe     = out_ch.failsafe;
      got.vehicle_mode = out_ch.vehicle_mode;
      lamps.check_lamp(got);
    end
  end

  // Watchdog: any cycle where an item moves on either side restarts the count.
  initial stall_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("tb_top: no item moved for %0d cycles", stall_cycles);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. Called at a clock edge; returns at the edge the item is accepted,
  // having made no assignment at that edge, so the next call may either keep
  // valid high or drop it for a gap.
  // --------------------------------------------------------------------------
  task automatic send_tick(logic nf, logic lu, logic [ChanW-1:0] l, logic [ChanW-1:0] r,
                           logic [TimeW-1:0] now);
    tick_t t;
    t = {nf, lu, l, r, now};
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.new_frame     <= nf;
    in_ch.link_up       <= lu;
    in_ch.left_channel  <= l;
    in_ch.right_channel <= r;
    in_ch.now_ms        <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // noted here, not in a monitor, so the next tick can aim at the timer edge
    lamps.note_tick(t);
    clock_ms = now;
  endtask

  // Drop valid and let all pending results drain.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (lamps.pending_lamps.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write every register, plus both spare indexes; 12-bit registers get
  // junk in the upper data bits, which must be dropped.
  task automatic apply_config(flasher_cfg_t c);
    logic [CfgW-1:0] vals [8];
    vals[CFG_BLINK_PERIOD] = c.period;
    vals[CFG_LAMP_ON]      = c.on_lvl;
    vals[CFG_LAMP_OFF]     = c.off_lvl;
    vals[CFG_LEFT_LOW]     = {4'($urandom_range(15)), c.lo};
    vals[CFG_LEFT_HIGH]    = {4'($urandom_range(15)), c.hi};
    vals[CFG_RIGHT_THRESH] = {4'($urandom_range(15)), c.rthr};
    vals[CfgIdxSpareLo]    = 16'($urandom);
    vals[CfgIdxSpareHi]    = 16'($urandom);
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CfgIdxW'(i);
      cfg_data  <= vals[i];
      lamps.write_reg(CfgIdxW'(i), vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic flasher_cfg_t random_cfg();
    flasher_cfg_t c;
    int lo;
    lo = $urandom_range(0, 3000);
    c.period  = 16'($urandom_range(0, 1000));
    c.on_lvl  = 16'($urandom);
    c.off_lvl = 16'($urandom);
    c.lo      = ChanW'(lo);
    c.hi      = ChanW'((lo + $urandom_range(2, 1000) > 4095) ? 4095
                                                           : lo + $urandom_range(2, 1000));
    c.rthr    = ChanW'($urandom_range(0, 4095));
    return c;
  endfunction

  // Channel values that do or do not raise a request under the current bands.
  function automatic logic [ChanW-1:0] left_on();
    int lo;
    int hi;
    lo = lamps.left_low;
    hi = lamps.left_high;
    if (hi > lo + 1) return ChanW'($urandom_range(lo + 1, hi - 1));
    return ChanW'($urandom_range(0, 4095));
  endfunction

  function automatic logic [ChanW-1:0] left_off();
    int lo;
    int hi;
    lo = lamps.left_low;
    hi = lamps.left_high;
    if ($urandom_range(1)) return ChanW'($urandom_range(0, lo));
    return ChanW'($urandom_range(hi, 4095));
  endfunction

  function automatic logic [ChanW-1:0] right_on();
    int th;
    th = lamps.right_thresh;
    if (th < 4095) return ChanW'($urandom_range(th + 1, 4095));
    return ChanW'(4095);
  endfunction

  function automatic logic [ChanW-1:0] right_off();
    return ChanW'($urandom_range(0, lamps.right_thresh));
  endfunction

  // Values on and around the compare edges, plus the extremes.
  function automatic logic [ChanW-1:0] near_edge(int a, int b);
    int v;
    case ($urandom_range(5))
      0: v = 0;
      1: v = 4095;
      2: v = a;
      3: v = a + 1;
      4: v = b - 1;
      default: v = $urandom_range(0, 4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return ChanW'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Random ticks. Switches follow held patterns so that a direction runs
  // long enough to flash and hand over; frames come now and then and mostly
  // carry a good link, so parked/hazard shows up in short bursts. Time mostly
  // creeps forward at a rate scaled to the period, with shots at the exact
  // toggle edge, wrap-around and random jumps.
  // --------------------------------------------------------------------------
  task automatic run_phase(int n_ticks);
    switch_seg_t      seg;
    int               seg_left;
    logic             nf;
    logic             lu;
    logic [ChanW-1:0] l;
    logic [ChanW-1:0] r;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] p;
    int unsigned      pick;
    seg = SEG_NONE;
    seg_left = 0;
    for (int i = 0; i < n_ticks; i++) begin
      if (seg_left == 0) begin
        seg = switch_seg_t'($urandom_range(4));
        seg_left = $urandom_range(4, 40);
      end
      seg_left--;
      nf = ($urandom_range(99) < 25);
      lu = ($urandom_range(99) >= 12);
      case (seg)
        SEG_LEFT: begin
          l = left_on();
          r = right_off();
        end
        SEG_RIGHT: begin
          l = left_off();
          r = right_on();
        end
        SEG_BOTH: begin
          l = left_on();
          r = right_on();
        end
        SEG_NOISE: begin
          l = near_edge(lamps.left_low, lamps.left_high);
          r = near_edge(lamps.right_thresh, lamps.right_thresh + 1);
        end
        default: begin
          l = left_off();
          r = right_off();
        end
      endcase
      p = {16'd0, lamps.blink_period};
      pick = $urandom_range(99);
      if (pick < 5)       now = lamps.last_toggle + p;       // just short of a toggle
      else if (pick < 10) now = lamps.last_toggle + p + 1;   // just enough
      else if (pick < 13) now = $urandom;
      else if (pick < 16) now = 32'hFFFF_FFFF - $urandom_range(0, p);
      else                now = clock_ms + $urandom_range(0, p / 3 + 1);
      send_tick(nf, lu, l, r, now);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    lamps = new();
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.new_frame      = 1'b0;
    in_ch.link_up        = 1'b0;
    in_ch.left_channel   = '0;
    in_ch.right_channel  = '0;
    in_ch.now_ms         = '0;
    send_idle_pct        = 16;
    recv_idle_pct        = 48;
    hold_off_req         = 1'b0;
    settings_used        = 1;
    clock_ms             = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    lamps.clear();

    // Directed ticks under reset registers (period 400, left band 1300..1700,
    // right above 1700).
    send_tick(1'b0, 1'b0, 12'd0, 12'd0, 32'd0);             // parked: hazard, no elapsed
    send_tick(1'b0, 1'b0, 12'hFFF, 12'hFFF, 32'd400);       // elapsed equals period
    send_tick(1'b0, 1'b1, 12'd1500, 12'd0, 32'd401);        // link bit without frame
    send_tick(1'b1, 1'b1, 12'd1500, 12'd1800, 32'd500);     // standby, both, no direction
    send_tick(1'b0, 1'b0, 12'd1500, 12'd1800, 32'd802);     // cycle ends, goes off
    send_tick(1'b0, 1'b0, 12'd1500, 12'd1800, 32'd1500);    // off: dark, timer kept
    send_tick(1'b0, 1'b0, 12'd1301, 12'd0, 32'd1600);       // left, just inside band
    send_tick(1'b0, 1'b0, 12'd1699, 12'd4095, 32'd2001);    // both after left
    send_tick(1'b0, 1'b0, 12'd1300, 12'd1700, 32'd2100);    // band edges: nothing
    send_tick(1'b0, 1'b0, 12'd1700, 12'd1701, 32'd2402);    // right queued behind left
    send_tick(1'b0, 1'b0, 12'd1500, 12'd1701, 32'd2803);    // both after right
    send_tick(1'b0, 1'b0, 12'd1500, 12'd1701, 32'd3204);
    send_tick(1'b0, 1'b0, 12'd4095, 12'd2048, 32'd3605);
    send_tick(1'b1, 1'b0, 12'd0, 12'd0, 32'd3700);          // link lost: hazard at once
    send_tick(1'b0, 1'b0, 12'd0, 12'd0, 32'hFFFF_FFFF);     // huge jump
    send_tick(1'b1, 1'b1, 12'd0, 12'd0, 32'h0000_0100);     // across the wrap
    send_tick(1'b0, 1'b1, 12'd0, 12'd0, 32'h0000_0300);
    send_tick(1'b0, 1'b0, 12'd2048, 12'd2048, 32'h0000_0600);
    send_tick(1'b1, 1'b0, 12'hAAA, 12'h555, 32'hAAAA_AAAA);
    send_tick(1'b1, 1'b1, 12'h555, 12'hAAA, 32'h5555_5555);
    send_tick(1'b0, 1'b0, 12'h555, 12'hAAA, 32'h0000_0000);
    settle();

    // Reset registers, plus one long output stall.
    hold_off_req = 1'b1;
    run_phase(300);
    settle();

    // Low extremes: toggle on any nonzero elapsed time, widest left band.
    apply_config('{16'd0, 16'd0, 16'hFFFF, 12'd0, 12'hFFF, 12'd0});
    run_phase(250);
    settle();

    // Swap the idle pattern: sender busy-idle, receiver mostly ready.
    send_idle_pct = 48;
    recv_idle_pct = 16;
    apply_config(random_cfg());
    run_phase(300);
    settle();

    // High extremes: longest period, no switch can ever request.
    apply_config('{16'hFFFF, 16'hFFFF, 16'd0, 12'hFFF, 12'd0, 12'hFFF});
    run_phase(150);
    settle();

    // No idling; the long stall here backs the block up against a busy sender.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_config(random_cfg());
    hold_off_req = 1'b1;
    run_phase(400);
    settle();

    apply_config('{16'd25, 16'h8000, 16'h7FFF, 12'd1300, 12'd1700, 12'd1700});
    run_phase(400);
    settle();
    repeat (8) @(posedge clk);

    if (lamps.pending_lamps.size() != 0) begin
      $display("tb_top: %0d lamp results never arrived", lamps.pending_lamps.size());
      lamps.faults += lamps.pending_lamps.size();
    end

    $display("tb_top: %0d ticks, %0d lamp results checked, %0d toggles, %0d mismatches",
             lamps.ticks, lamps.lamps_seen, lamps.toggles, lamps.faults);
    $display("tb_top: %0d register sets incl. extremes, link loss, hand-over, output stalls",
             settings_used);
    if (lamps.faults == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tshf_pkg.sv
rtl/core/tshf_if.sv
rtl/core/turn_signal_hazard_flasher_top.sv
tb/sv/flasher_tb_pkg.sv
tb/sv/tb_top.sv
